[rtl/lcp_pkg.sv]
// Shared types, character codes and keyword tables for the LED command text parser.
// No dependencies; imported by every module of the block.
package lcp_pkg;

    localparam int COUNT_W    = 6;
    localparam int ACC_W      = 9;
    localparam int NUM_FIELDS = 5;
    localparam int INDEX_W    = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 6'd63;
    localparam logic [COUNT_W-1:0] START_LEN     = 6'd9;
    localparam logic [COUNT_W-1:0] STOP_LEN      = 6'd8;
    localparam logic [ACC_W-1:0]   ACC_SAT       = 9'd256;
    localparam logic [7:0]         LED_MAX_RESET = 8'd13;
    localparam logic [INDEX_W-1:0] FIELD_COUNT   = 3'd5;
    localparam logic [INDEX_W-1:0] LAST_FIELD    = 3'd4;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_L     = 8'h4C;

    typedef enum logic [1:0] {
        CMD_UNKNOWN = 2'd0,
        CMD_START   = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_SET     = 2'd3
    } t_cmd;

    // Position inside one token
    typedef enum logic [3:0] {
        PH_BETWEEN = 4'b0001,
        PH_SPACE   = 4'b0010,
        PH_SIGN    = 4'b0100,
        PH_DIGITS  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic kept;       // this byte lies inside the kept window of a set command
        logic start_hit;  // string so far is exactly "START LED"
        logic stop_hit;   // string so far is exactly "STOP LED"
        logic prefix_ok;  // string so far starts with "L,"
    } t_frame_info;

    typedef struct packed {
        logic                             set_ok;  // five clean tokens, ends in ';'
        logic [NUM_FIELDS-1:0][7:0]       values;  // token values, entry 0 first
    } t_token_info;

    // "START LED"
    function automatic logic [7:0] start_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h53;
            4'd1:    ch = 8'h54;
            4'd2:    ch = 8'h41;
            4'd3:    ch = 8'h52;
            4'd4:    ch = 8'h54;
            4'd5:    ch = 8'h20;
            4'd6:    ch = 8'h4C;
            4'd7:    ch = 8'h45;
            4'd8:    ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "STOP LED"
    function automatic logic [7:0] stop_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h53;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h4F;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h20;
            3'd5:    ch = 8'h4C;
            3'd6:    ch = 8'h45;
            default: ch = 8'h44;
        endcase
        return ch;
    endfunction

endpackage

[rtl/lcp_frame_match.sv]
// Byte counter and whole-string keyword matching (START/STOP keywords, "L," prefix).
// Depends on lcp_pkg.
module lcp_frame_match #(
    parameter int KEPT_BYTES = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_last,
    input  logic [7:0]          i_byte,
    output lcp_pkg::t_frame_info o_info
);
    import lcp_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_start, n_start;
    logic               r_stop, n_stop;
    logic               r_prefix, n_prefix;

    always_comb begin
        n_start  = r_start && (r_count < START_LEN) && (i_byte == start_char(r_count[3:0]));
        n_stop   = r_stop && (r_count < STOP_LEN) && (i_byte == stop_char(r_count[2:0]));
        n_prefix = r_prefix && !((r_count == 6'd0 && i_byte != CH_L) ||
                                 (r_count == 6'd1 && i_byte != CH_COMMA));
        n_count  = (r_count < COUNT_MAX) ? r_count + 6'd1 : r_count;

        o_info.kept      = (r_count >= 6'd2) && (r_count < COUNT_W'(KEPT_BYTES));
        o_info.start_hit = n_start && (n_count == START_LEN);
        o_info.stop_hit  = n_stop && (n_count == STOP_LEN);
        o_info.prefix_ok = n_prefix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count  <= '0;
            r_start  <= 1'b1;
            r_stop   <= 1'b1;
            r_prefix <= 1'b1;
        end else if (i_step) begin
            r_count  <= n_count;
            r_start  <= n_start;
            r_stop   <= n_stop;
            r_prefix <= n_prefix;
        end
    end

endmodule

[rtl/lcp_token_parser.sv]
// Token scanner for set commands: whitespace, sign, saturating decimal value, five fields.
// Depends on lcp_pkg.
module lcp_token_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_last,
    input  logic                 i_kept,
    input  logic [7:0]           i_byte,
    output lcp_pkg::t_token_info o_info
);
    import lcp_pkg::*;

    t_phase             r_phase, n_phase, ph0;
    logic [ACC_W-1:0]   r_acc, n_acc, acc_dig;
    logic               r_neg, n_neg;
    logic [INDEX_W-1:0] r_index, n_index;
    logic               r_pending, n_pending;
    logic               r_err, n_err;
    logic [7:0]         r_field [NUM_FIELDS];

    logic        is_digit, is_space, is_sign, feed, err_pend;
    logic        close_err, close_wr, field_wr;
    logic [11:0] acc_mul;

    always_comb begin
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        is_space = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
        is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
        feed     = i_kept && (i_byte != CH_SEMI);
        // a held ';' that is not the final kept byte is an invalid character
        err_pend = i_kept && r_pending;
        ph0      = (err_pend && r_phase == PH_BETWEEN) ? PH_SPACE : r_phase;

        acc_mul  = 12'({3'b000, r_acc}) * 12'd10 + 12'(i_byte[3:0]);
        acc_dig  = (acc_mul > 12'(ACC_SAT)) ? ACC_SAT : acc_mul[ACC_W-1:0];

        // closing the current token ("-0" is the only legal negative)
        close_wr  = (ph0 == PH_DIGITS) && (r_index < FIELD_COUNT);
        close_err = (ph0 == PH_SPACE) || (ph0 == PH_SIGN) ||
                    ((ph0 == PH_DIGITS) &&
                     ((r_neg ? (r_acc != '0) : r_acc[ACC_W-1]) || (r_index >= FIELD_COUNT)));

        n_phase   = i_kept ? ph0 : r_phase;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_index   = r_index;
        n_err     = r_err | err_pend;
        n_pending = i_kept ? (i_byte == CH_SEMI) : r_pending;
        field_wr  = 1'b0;

        if (feed) begin
            if (i_byte == CH_COMMA) begin
                n_err    = n_err | close_err;
                field_wr = close_wr;
                if (close_wr) begin
                    n_index = r_index + 3'd1;
                end
                n_phase = PH_BETWEEN;
                n_acc   = '0;
                n_neg   = 1'b0;
            end else if (is_digit) begin
                n_acc   = acc_dig;
                n_phase = PH_DIGITS;
            end else if (is_space) begin
                if (ph0 == PH_BETWEEN || ph0 == PH_SPACE) begin
                    n_phase = PH_SPACE;
                end else begin
                    n_err = 1'b1;
                end
            end else if (is_sign) begin
                if (ph0 == PH_BETWEEN || ph0 == PH_SPACE) begin
                    n_phase = PH_SIGN;
                    n_neg   = (i_byte == CH_MINUS);
                end else begin
                    n_err = 1'b1;
                end
            end else begin
                if (ph0 == PH_BETWEEN) begin
                    n_phase = PH_SPACE;
                end
                n_err = 1'b1;
            end
        end

        // end of string: close the open token, which must be the fifth
        o_info.set_ok = n_pending && !(r_err || err_pend || close_err) &&
                        ((r_index == FIELD_COUNT && !close_wr) ||
                         (r_index == LAST_FIELD && close_wr));
        for (int k = 0; k < NUM_FIELDS - 1; k++) begin
            o_info.values[k] = r_field[k];
        end
        o_info.values[NUM_FIELDS-1] = (r_index == LAST_FIELD) ? r_acc[7:0]
                                                               : r_field[NUM_FIELDS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase   <= PH_BETWEEN;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_index   <= '0;
            r_pending <= 1'b0;
            r_err     <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_index   <= n_index;
            r_pending <= n_pending;
            r_err     <= n_err;
        end
    end

    // field store, no reset: each entry is written before it is read
    for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_field
        always_ff @(posedge i_clk) begin
            if (i_step && field_wr && (r_index == INDEX_W'(g))) begin
                r_field[g] <= r_acc[7:0];
            end
        end
    end

endmodule

[rtl/led_command_text_parser_unit.sv]
// Top level of the LED command text parser: input register, parser blocks, result register.
// Depends on lcp_pkg, lcp_frame_match and lcp_token_parser.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] byte_char, tlast is_last
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser[1:0] command, tdata: led, bright, r, g, b
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data[7:0] led_max
//
// One byte per cycle while nothing stalls. A byte is held in the input register while the
// frame matcher and token scanner update; the final byte of a string loads the result
// register as it leaves the input register, and the result stays valid until it is taken.
// Reset (synchronous, active low) clears the parser control state and sets led_max to 13.
// Only a final byte can stall, and only while the previous result is still not taken.
module led_command_text_parser_unit #(
    parameter int KEPT_BYTES = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_char
    input  logic        s_axis_tlast,   // is_last
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] led_number, [15:8] brightness,
                                        // [23:16] red, [31:24] green, [39:32] blue
    output logic [1:0]  m_axis_tuser,   // [1:0] command
    // led_max register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import lcp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic       r_out_valid;
    t_cmd       r_out_cmd, n_out_cmd;
    logic [NUM_FIELDS-1:0][7:0] r_out_fields, n_out_fields;

    logic [7:0] r_led_max;

    logic stall, step, in_accept;
    t_frame_info frame;
    t_token_info tok;

    // a final byte may only proceed if the result register is free or draining
    assign stall         = r_in_valid && r_in_last && r_out_valid && !m_axis_tready;
    assign step          = r_in_valid && !stall;
    assign s_axis_tready = !stall;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_max <= LED_MAX_RESET;
        end else if (i_cfg_valid) begin
            r_led_max <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    lcp_frame_match #(
        .KEPT_BYTES (KEPT_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_last  (r_in_last),
        .i_byte  (r_in_byte),
        .o_info  (frame)
    );

    lcp_token_parser u_token (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_last  (r_in_last),
        .i_kept  (frame.kept),
        .i_byte  (r_in_byte),
        .o_info  (tok)
    );

    // keyword matches win over a set command; a set needs the LED in 1..led_max
    always_comb begin
        n_out_fields = '0;
        if (frame.start_hit) begin
            n_out_cmd = CMD_START;
        end else if (frame.stop_hit) begin
            n_out_cmd = CMD_STOP;
        end else if (frame.prefix_ok && tok.set_ok && (tok.values[0] != 8'd0) &&
                     (tok.values[0] <= r_led_max)) begin
            n_out_cmd    = CMD_SET;
            n_out_fields = tok.values;
        end else begin
            n_out_cmd = CMD_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_cmd    <= n_out_cmd;
            r_out_fields <= n_out_fields;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_fields;
    assign m_axis_tuser  = r_out_cmd;

    // a set result always carries a nonzero LED number
    a_set_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd == CMD_SET) |-> (r_out_fields[0] != 8'd0))
        else $error("set result with LED number zero");

    // every other result carries zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd != CMD_SET) |-> (r_out_fields == '0))
        else $error("non-set result with nonzero fields");

    // the final byte of a string always produces a result
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |=> r_out_valid)
        else $error("final byte left no result");

    // the input side stalls only on a final byte facing a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending result");

endmodule

[bench/tb_led_command_text_parser_unit.sv]
// Self-checking bench for led_command_text_parser_unit: directed and random command strings.
// A byte-level predictor in the bench computes each expected result; compared as results arrive.
// Depends on lcp_pkg and the RTL of the block only.
module tb_led_command_text_parser_unit;
    import lcp_pkg::*;

    localparam int KEPT = 31;

    // Expected result, laid out like {m_axis_tdata, m_axis_tuser}
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] bright;
        logic [7:0] led;
        t_cmd       cmd;
    } t_led_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'h00;

    // idling odds, in percent per cycle
    int src_gap_pct = 0;
    int sink_stall_pct = 0;

    int error_count = 0;
    int bytes_sent = 0;

    t_led_result expected_results[$];
    logic [7:0]  text_buf[$];    // command string being built, then sent

    // predictor state for the string in flight
    string      start_text = "START LED";
    string      stop_text = "STOP LED";
    logic [7:0] led_limit;
    logic [5:0] str_len;
    logic       start_seen;
    logic       stop_seen;
    logic       set_prefix;
    logic [2:0] tok_count;
    t_phase     tok_phase;
    logic [8:0] tok_acc;
    logic       tok_neg;
    logic       semi_held;
    logic       parse_err;
    logic [7:0] tok_val[5];

    led_command_text_parser_unit #(
        .KEPT_BYTES(KEPT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("** led_command_text_parser_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_string();
        str_len = '0;
        start_seen = 1'b1;
        stop_seen = 1'b1;
        set_prefix = 1'b1;
        tok_count = '0;
        tok_phase = PH_BETWEEN;
        tok_acc = '0;
        tok_neg = 1'b0;
        semi_held = 1'b0;
        parse_err = 1'b0;
    endfunction

    // A comma (or the final ';') ends a token
    function automatic void close_token();
        if (tok_phase == PH_SPACE || tok_phase == PH_SIGN) begin
            parse_err = 1'b1;
        end else if (tok_phase == PH_DIGITS) begin
            // "-0" is the only negative value allowed
            if (tok_neg ? (tok_acc != 0) : (tok_acc > 9'd255))
                parse_err = 1'b1;
            if (tok_count >= FIELD_COUNT) begin
                parse_err = 1'b1;    // sixth token
            end else begin
                tok_val[tok_count] = tok_acc[7:0];
                tok_count++;
            end
        end
        tok_phase = PH_BETWEEN;
        tok_acc = '0;
        tok_neg = 1'b0;
    endfunction

    function automatic void scan_char(input logic [7:0] ch);
        int nv;
        if (ch == CH_COMMA) begin
            close_token();
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            nv = int'(tok_acc) * 10 + int'(ch) - int'(CH_ZERO);
            tok_acc = (nv > int'(ACC_SAT)) ? ACC_SAT : nv[8:0];
            tok_phase = PH_DIGITS;
        end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            if (tok_phase == PH_BETWEEN || tok_phase == PH_SPACE)
                tok_phase = PH_SPACE;
            else
                parse_err = 1'b1;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            if (tok_phase == PH_BETWEEN || tok_phase == PH_SPACE) begin
                tok_phase = PH_SIGN;
                tok_neg = (ch == CH_MINUS);
            end else begin
                parse_err = 1'b1;
            end
        end else begin
            // anything else spoils the token
            if (tok_phase == PH_BETWEEN)
                tok_phase = PH_SPACE;
            parse_err = 1'b1;
        end
    endfunction

    // Called on every accepted byte; queues a result on the final one
    function automatic void predict_byte(input logic [7:0] ch, input logic last);
        int          p;
        t_led_result res;
        p = int'(str_len);
        if (p >= start_text.len() || ch != start_text[p])
            start_seen = 1'b0;
        if (p >= stop_text.len() || ch != stop_text[p])
            stop_seen = 1'b0;
        if ((p == 0 && ch != CH_L) || (p == 1 && ch != CH_COMMA))
            set_prefix = 1'b0;
        // set parser sees only the kept window; a ';' counts only as its last byte
        if (p >= 2 && p < KEPT) begin
            if (semi_held) begin
                scan_char(CH_SEMI);
                semi_held = 1'b0;
            end
            if (ch == CH_SEMI)
                semi_held = 1'b1;
            else
                scan_char(ch);
        end
        if (str_len < COUNT_MAX)
            str_len++;
        if (!last)
            return;
        res = '0;
        if (start_seen && str_len == START_LEN) begin
            res.cmd = CMD_START;
        end else if (stop_seen && str_len == STOP_LEN) begin
            res.cmd = CMD_STOP;
        end else if (set_prefix && semi_held) begin
            close_token();
            if (!parse_err && tok_count == FIELD_COUNT &&
                tok_val[0] >= 8'd1 && tok_val[0] <= led_limit) begin
                res.cmd = CMD_SET;
                res.led = tok_val[0];
                res.bright = tok_val[1];
                res.red = tok_val[2];
                res.green = tok_val[3];
                res.blue = tok_val[4];
            end
        end
        expected_results.push_back(res);
        clear_string();
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_led_result want;
        t_led_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_led_result'({m_axis_tdata, m_axis_tuser});
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h %h", $time,
                         m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("command", want.cmd, got.cmd);
                check_field("led_number", want.led, got.led);
                check_field("brightness", want.bright, got.bright);
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // One byte over the stream; returns at the edge where it is taken
    task automatic send_byte(input logic [7:0] ch, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(ch, last);
        bytes_sent++;
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    function automatic void append_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    task automatic send_str(input string s);
        text_buf.delete();
        append_text(s);
        send_text();
    endtask

    // Stop sending, wait for every result, then let the pipeline drain
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_led_max(input logic [7:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        led_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random string builders
    // ------------------------------------------------------------------

    function automatic void append_space();
        int k;
        k = $urandom_range(0, 5);
        text_buf.push_back(k == 0 ? CH_SPACE : 8'(8 + k));
    endfunction

    // Mostly well-formed "L," commands with random tokens, some broken
    function automatic void build_set_command();
        int n_tok;
        int k;
        int v;
        int r;
        text_buf.delete();
        append_text("L,");
        n_tok = ($urandom_range(0, 99) < 85) ? 5 : $urandom_range(0, 7);
        for (k = 0; k < n_tok; k++) begin
            if (k > 0)
                text_buf.push_back(CH_COMMA);
            if ($urandom_range(0, 99) < 8)
                text_buf.push_back(CH_COMMA);           // empty token
            if ($urandom_range(0, 99) < 20) begin
                append_space();
                if ($urandom_range(0, 1) == 1)
                    append_space();
            end
            r = $urandom_range(0, 99);
            if (k == 0)
                v = ($urandom_range(0, 99) < 80) ? $urandom_range(0, int'(led_limit) + 2)
                                                 : $urandom_range(0, 300);
            else if (r < 85)
                v = $urandom_range(0, 255);
            else if (r < 95)
                v = $urandom_range(256, 999);
            else
                v = $urandom_range(255, 256);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                text_buf.push_back(CH_MINUS);
                if ($urandom_range(0, 99) < 70)
                    v = 0;
            end else if (r < 16) begin
                text_buf.push_back(CH_PLUS);
            end
            if ($urandom_range(0, 99) < 8)
                text_buf.push_back(CH_ZERO);            // leading zero
            append_text($sformatf("%0d", v));
        end
        if ($urandom_range(0, 99) < 5)
            text_buf.push_back(CH_COMMA);
        if ($urandom_range(0, 99) < 93)
            text_buf.push_back(CH_SEMI);
        if ($urandom_range(0, 99) < 4)
            text_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 6)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // START/STOP keywords, exact or slightly off
    function automatic void build_keyword();
        text_buf.delete();
        if ($urandom_range(0, 1) == 1)
            append_text(start_text);
        else
            append_text(stop_text);
        case ($urandom_range(0, 3))
            2: begin
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            3: begin
                if ($urandom_range(0, 1) == 1)
                    void'(text_buf.pop_back());
                else
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endfunction

    function automatic void build_noise();
        int n;
        int k;
        text_buf.delete();
        n = $urandom_range(1, 12);
        if ($urandom_range(0, 99) < 30)
            append_text("L,");
        for (k = 0; k < n; k++)
            text_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_keywords();
        int k;
        send_str("START LED");
        send_str("STOP LED");
        send_str("START LE");
        send_str("START LEDD");
        send_str("STOP LEDX");
        send_str("START  LED");
        send_str("S");
        send_byte(8'h00, 1'b1);     // zero byte alone
        send_byte(8'hFF, 1'b1);
        // long string: length counter must saturate, not wrap back to 9
        text_buf.delete();
        append_text("START LED");
        for (k = 0; k < 64; k++)
            text_buf.push_back(8'h41);
        send_text();
    endtask

    task automatic test_set_syntax();
        send_str("L,1,2,3,4,5;");
        send_str("L,13,255,0,+7,-0;");
        send_str("L,,1,,2,3,,,4,5,;");      // empty tokens collapse
        send_str("L,1,2,3,4,5,6;");         // sixth token
        send_str("L,1,2,3,4;");
        send_str("L,1,999,3,4,5;");         // saturating value
        send_str("L,1,-1,3,4,5;");
        send_str("L,1,2;3,4,5;");           // stray semicolon
        send_str("L,0,2,3,4,5;");
        send_str("L,14,2,3,4,5;");          // above reset led_max
        send_str("L,1,2,3,4,5");
        send_str("L,1,2,3,4,5;;");
        send_str("L,+ 1,2,3,4,5;");
        send_str("L,1 ,2,3,4,5;");
        send_str("l,1,2,3,4,5;");
        // all C whitespace characters ahead of tokens
        text_buf.delete();
        append_text("L, 1,");
        text_buf.push_back(8'h09);
        append_text("2,");
        text_buf.push_back(8'h0A);
        append_text("3,");
        text_buf.push_back(8'h0B);
        text_buf.push_back(8'h0C);
        append_text("4,");
        text_buf.push_back(8'h0D);
        append_text("5;");
        send_text();
        // zero byte and 0xFF inside tokens
        text_buf.delete();
        append_text("L,1,2");
        text_buf.push_back(8'h00);
        append_text(",3,4,5;");
        send_text();
        text_buf.delete();
        append_text("L,1,2,3,4,5");
        text_buf.push_back(8'hFF);
        text_buf.push_back(CH_SEMI);
        send_text();
    endtask

    task automatic test_kept_window();
        // ';' lands exactly on the last kept byte, junk after it is ignored
        text_buf.delete();
        append_text("L,1,2,3,4,");
        repeat (19) text_buf.push_back(CH_SPACE);
        append_text("5;ZZ");
        send_text();
        // one byte later the ';' falls outside the window
        text_buf.delete();
        append_text("L,1,2,3,4,");
        repeat (20) text_buf.push_back(CH_SPACE);
        append_text("5;");
        send_text();
        // very long tail: counter saturation keeps the window closed
        text_buf.delete();
        append_text("L,9,8,7,6,");
        repeat (19) text_buf.push_back(CH_SPACE);
        append_text("5;");
        repeat (45) text_buf.push_back(8'h5A);
        send_text();
        send_str("L,1,2,3,4,5;X");
    endtask

    task automatic test_led_max_limits();
        write_led_max(8'd0);        // nothing accepted
        send_str("L,1,1,1,1,1;");
        send_str("L,0,1,1,1,1;");
        write_led_max(8'd1);
        send_str("L,1,9,8,7,6;");
        send_str("L,2,9,8,7,6;");
        write_led_max(8'd255);
        send_str("L,255,255,255,255,255;");
        send_str("L,256,1,1,1,1;");
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int start_count;
        int r;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                build_set_command();
            else if (r < 80)
                build_keyword();
            else
                build_noise();
            send_text();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        led_limit = LED_MAX_RESET;
        tok_val = '{default: 8'h00};
        clear_string();

        // sender mostly busy, receiver stalls a lot
        src_gap_pct = 6;
        sink_stall_pct = 74;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_keywords();
        test_set_syntax();
        test_kept_window();
        test_led_max_limits();
        write_led_max(8'($urandom_range(1, 254)));
        test_random_traffic(280);

        // sender gaps, receiver nearly always ready
        wait_quiet();
        src_gap_pct = 74;
        sink_stall_pct = 6;
        write_led_max(8'd255);
        test_random_traffic(250);

        // full rate both sides
        wait_quiet();
        src_gap_pct = 0;
        sink_stall_pct = 0;
        write_led_max(8'($urandom_range(1, 40)));
        test_random_traffic(250);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("** led_command_text_parser_unit: PASSED **");
        else
            $display("** led_command_text_parser_unit: FAILED **");
        $finish;
    end

endmodule

[sim.f]
rtl/lcp_pkg.sv
rtl/lcp_frame_match.sv
rtl/lcp_token_parser.sv
rtl/led_command_text_parser_unit.sv
bench/tb_led_command_text_parser_unit.sv
